>>> design/ps2rb_pkg.sv
package ps2rb_pkg;

  // Ring geometry: one entry always stays free, so a ring holds DEPTH-1 bytes
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned CMP_W  = (PTR_W > CNT_W) ? PTR_W : CNT_W;
  localparam int unsigned DATA_W = 8;

  localparam logic [CNT_W-1:0] CNT_MAX  = '1;
  localparam logic [CNT_W-1:0] CNT_FULL =
      (DEPTH - 1 > 15) ? CNT_MAX : CNT_W'(DEPTH - 1);

  // Operation codes
  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_POLL = 2'd2;

  // Port select
  localparam logic CH_KBD   = 1'b0;
  localparam logic CH_MOUSE = 1'b1;

  // Requests into one ring for the current beat
  typedef struct packed {
    logic push;
    logic pop;
  } ring_req_t;

  // Outcome of those requests
  typedef struct packed {
    logic             push_ok;
    logic             pop_ok;
    logic [CNT_W-1:0] count;
  } ring_sts_t;

  // Pointer step with wrap from DEPTH-1 to 0
  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

endpackage

>>> design/ps2rb_ram.sv
module ps2rb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/ps2rb_ring.sv
module ps2rb_ring (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ps2rb_pkg::ring_req_t          req_i,
  input  logic [ps2rb_pkg::DATA_W-1:0]  push_data_i,
  output ps2rb_pkg::ring_sts_t          sts_o,
  output logic [ps2rb_pkg::DATA_W-1:0]  pop_data_o
);

  localparam int unsigned PW = ps2rb_pkg::PTR_W;
  localparam int unsigned DW = ps2rb_pkg::DATA_W;

  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic          empty, full;
  logic          push_ok, pop_ok;
  logic [DW-1:0] ram_rdata, head_data;
  logic          fwd_q;
  logic [DW-1:0] fwd_data_q;
  logic [PW:0]   span;
  logic [PW-1:0] cnt;
  logic [ps2rb_pkg::CMP_W-1:0] cnt_ext;

  assign empty = (head_q == tail_q);
  assign full  = (ps2rb_pkg::wrap_next(tail_q) == head_q);

  // A pop may take the byte pushed in the same beat when the ring was empty
  assign push_ok = req_i.push & ~full;
  assign pop_ok  = req_i.pop & (~empty | push_ok);

  assign tail_d = push_ok ? ps2rb_pkg::wrap_next(tail_q) : tail_q;
  assign head_d = pop_ok  ? ps2rb_pkg::wrap_next(head_q) : head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fwd_q  <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fwd_q  <= push_ok & (tail_q == head_d);
    end
  end

  // Write data kept for the read-during-write case
  always_ff @(posedge clk_i) begin
    fwd_data_q <= push_data_i;
  end

  // RAM reads the next head ahead, so its output is the head entry
  ps2rb_ram #(
    .WIDTH (DW),
    .DEPTH (ps2rb_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (tail_q),
    .wdata_i (push_data_i),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  assign head_data  = fwd_q ? fwd_data_q : ram_rdata;
  assign pop_data_o = empty ? push_data_i : head_data;

  // Occupancy after this beat, saturated to the count field
  always_comb begin
    if (tail_d >= head_d) begin
      span = {1'b0, tail_d} - {1'b0, head_d};
    end else begin
      span = {1'b0, tail_d} + (PW + 1)'(ps2rb_pkg::DEPTH) - {1'b0, head_d};
    end
  end

  assign cnt     = span[PW-1:0];
  assign cnt_ext = ps2rb_pkg::CMP_W'(cnt);

  always_comb begin
    sts_o.push_ok = push_ok;
    sts_o.pop_ok  = pop_ok;
    if (cnt_ext > ps2rb_pkg::CMP_W'(ps2rb_pkg::CNT_MAX)) begin
      sts_o.count = ps2rb_pkg::CNT_MAX;
    end else begin
      sts_o.count = cnt_ext[ps2rb_pkg::CNT_W-1:0];
    end
  end

endmodule

>>> design/ps2_dual_port_ring_buffers.sv
// Receive and transmit byte rings for a keyboard and a mouse PS/2 port.
//
// Input channel (in_valid_i/in_ready_o) carries one operation per beat:
// send (queue send_byte_i for the selected port, then poll both ports),
// read (dequeue one received byte of the selected port) or poll (sample
// both ports' status: store a flagged received byte, emit the oldest queued
// byte to a port that is clear to send). Keyboard is polled before mouse.
// Output channel (out_valid_o/out_ready_i) returns exactly one result beat
// per operation.
//
// The result is registered: it sits in the output register the cycle after
// acceptance. Throughput is one operation per cycle unless the receiver
// stalls; each ring does one RAM write and one prefetched RAM read per beat.
//
// Reset empties all four rings and clears the output valid. When the
// receiver stalls, the result is held and in_ready_o drops until it is
// taken. A send to a full transmit ring is refused; a byte arriving at a
// full receive ring is dropped and reported in rx_dropped_o.
module ps2_dual_port_ring_buffers (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic       channel_i,
  input  logic [7:0] send_byte_i,
  input  logic       kbd_received_i,
  input  logic       kbd_clear_to_send_i,
  input  logic [7:0] kbd_rx_byte_i,
  input  logic       mouse_received_i,
  input  logic       mouse_clear_to_send_i,
  input  logic [7:0] mouse_rx_byte_i,

  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       read_valid_o,
  output logic [7:0] read_byte_o,
  output logic       send_accepted_o,
  output logic       kbd_tx_valid_o,
  output logic [7:0] kbd_tx_byte_o,
  output logic       mouse_tx_valid_o,
  output logic [7:0] mouse_tx_byte_o,
  output logic [3:0] kbd_rx_count_o,
  output logic [3:0] mouse_rx_count_o,
  output logic [1:0] rx_dropped_o
);

  logic accept;
  logic is_send, is_read, do_poll;
  logic sel_kbd, sel_mouse;

  ps2rb_pkg::ring_req_t kbd_rx_req, kbd_tx_req, mouse_rx_req, mouse_tx_req;
  ps2rb_pkg::ring_sts_t kbd_rx_sts, kbd_tx_sts, mouse_rx_sts, mouse_tx_sts;
  logic [7:0] kbd_rx_data, kbd_tx_data, mouse_rx_data, mouse_tx_data;

  logic       out_valid_q;
  logic       read_valid_d, read_valid_q;
  logic [7:0] read_byte_d, read_byte_q;
  logic       send_acc_d, send_acc_q;
  logic       kbd_txv_d, kbd_txv_q;
  logic [7:0] kbd_txb_d, kbd_txb_q;
  logic       mouse_txv_d, mouse_txv_q;
  logic [7:0] mouse_txb_d, mouse_txb_q;
  logic [3:0] kbd_cnt_d, kbd_cnt_q;
  logic [3:0] mouse_cnt_d, mouse_cnt_q;
  logic [1:0] drop_d, drop_q;

  // Handshake: a new beat enters whenever the result slot frees up
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  // Operation decode; the unused code does nothing
  assign is_send   = (op_i == ps2rb_pkg::OP_SEND);
  assign is_read   = (op_i == ps2rb_pkg::OP_READ);
  assign do_poll   = is_send | (op_i == ps2rb_pkg::OP_POLL);
  assign sel_kbd   = (channel_i == ps2rb_pkg::CH_KBD);
  assign sel_mouse = (channel_i == ps2rb_pkg::CH_MOUSE);

  // Ring requests for this beat
  always_comb begin
    kbd_tx_req.push   = accept & is_send & sel_kbd;
    kbd_tx_req.pop    = accept & do_poll & kbd_clear_to_send_i;
    mouse_tx_req.push = accept & is_send & sel_mouse;
    mouse_tx_req.pop  = accept & do_poll & mouse_clear_to_send_i;
    kbd_rx_req.push   = accept & do_poll & kbd_received_i;
    kbd_rx_req.pop    = accept & is_read & sel_kbd;
    mouse_rx_req.push = accept & do_poll & mouse_received_i;
    mouse_rx_req.pop  = accept & is_read & sel_mouse;
  end

  ps2rb_ring u_kbd_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (kbd_rx_req),
    .push_data_i (kbd_rx_byte_i),
    .sts_o       (kbd_rx_sts),
    .pop_data_o  (kbd_rx_data)
  );

  ps2rb_ring u_kbd_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (kbd_tx_req),
    .push_data_i (send_byte_i),
    .sts_o       (kbd_tx_sts),
    .pop_data_o  (kbd_tx_data)
  );

  ps2rb_ring u_mouse_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mouse_rx_req),
    .push_data_i (mouse_rx_byte_i),
    .sts_o       (mouse_rx_sts),
    .pop_data_o  (mouse_rx_data)
  );

  ps2rb_ring u_mouse_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mouse_tx_req),
    .push_data_i (send_byte_i),
    .sts_o       (mouse_tx_sts),
    .pop_data_o  (mouse_tx_data)
  );

  // Result fields; bytes read as zero when nothing moved
  always_comb begin
    read_valid_d = (kbd_rx_req.pop & kbd_rx_sts.pop_ok)
                 | (mouse_rx_req.pop & mouse_rx_sts.pop_ok);
    read_byte_d  = '0;
    if (read_valid_d) begin
      read_byte_d = sel_mouse ? mouse_rx_data : kbd_rx_data;
    end
    send_acc_d  = kbd_tx_sts.push_ok | mouse_tx_sts.push_ok;
    kbd_txv_d   = kbd_tx_sts.pop_ok;
    kbd_txb_d   = kbd_txv_d ? kbd_tx_data : 8'h00;
    mouse_txv_d = mouse_tx_sts.pop_ok;
    mouse_txb_d = mouse_txv_d ? mouse_tx_data : 8'h00;
    kbd_cnt_d   = kbd_rx_sts.count;
    mouse_cnt_d = mouse_rx_sts.count;
    drop_d      = {mouse_rx_req.push & ~mouse_rx_sts.push_ok,
                   kbd_rx_req.push & ~kbd_rx_sts.push_ok};
  end

  // Output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_valid_q <= read_valid_d;
      read_byte_q  <= read_byte_d;
      send_acc_q   <= send_acc_d;
      kbd_txv_q    <= kbd_txv_d;
      kbd_txb_q    <= kbd_txb_d;
      mouse_txv_q  <= mouse_txv_d;
      mouse_txb_q  <= mouse_txb_d;
      kbd_cnt_q    <= kbd_cnt_d;
      mouse_cnt_q  <= mouse_cnt_d;
      drop_q       <= drop_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_valid_o     = read_valid_q;
  assign read_byte_o      = read_byte_q;
  assign send_accepted_o  = send_acc_q;
  assign kbd_tx_valid_o   = kbd_txv_q;
  assign kbd_tx_byte_o    = kbd_txb_q;
  assign mouse_tx_valid_o = mouse_txv_q;
  assign mouse_tx_byte_o  = mouse_txb_q;
  assign kbd_rx_count_o   = kbd_cnt_q;
  assign mouse_rx_count_o = mouse_cnt_q;
  assign rx_dropped_o     = drop_q;

  // Every accepted beat produces a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted beat produced no result");

  // A dropped keyboard byte means the ring was full after the beat
  a_kbd_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rx_dropped_o[0]) |-> (kbd_rx_count_o == ps2rb_pkg::CNT_FULL))
    else $error("keyboard drop with ring not full");

  // A dropped mouse byte means the ring was full after the beat
  a_mouse_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rx_dropped_o[1]) |-> (mouse_rx_count_o == ps2rb_pkg::CNT_FULL))
    else $error("mouse drop with ring not full");

  // A read beat never polls and never sends
  a_read_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && read_valid_o) |->
      (!send_accepted_o && !kbd_tx_valid_o && !mouse_tx_valid_o && rx_dropped_o == 2'b00))
    else $error("read beat shows poll or send activity");

  // Idle transmit lanes carry a zero byte
  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !kbd_tx_valid_o && !mouse_tx_valid_o) |->
      (kbd_tx_byte_o == 8'h00 && mouse_tx_byte_o == 8'h00))
    else $error("transmit byte set without transmit valid");

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Local names for the package constants used below
  localparam int unsigned DEPTH    = ps2rb_pkg::DEPTH;
  localparam int unsigned PTR_W    = ps2rb_pkg::PTR_W;
  localparam logic [1:0]  OP_SEND  = ps2rb_pkg::OP_SEND;
  localparam logic [1:0]  OP_READ  = ps2rb_pkg::OP_READ;
  localparam logic [1:0]  OP_POLL  = ps2rb_pkg::OP_POLL;
  localparam logic        CH_KBD   = ps2rb_pkg::CH_KBD;
  localparam logic        CH_MOUSE = ps2rb_pkg::CH_MOUSE;

  // Undefined op code: the block must leave all rings alone
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam int N_DIR  = 23;
  localparam int N_RAND = 925;
  localparam int CHUNK  = 50;

  // One operation beat on the input channel
  typedef struct packed {
    logic [1:0] op;
    logic       ch;
    logic [7:0] send_byte;
    logic       kbd_rcv;
    logic       kbd_cts;
    logic [7:0] kbd_byte;
    logic       ms_rcv;
    logic       ms_cts;
    logic [7:0] ms_byte;
  } ps2_op_t;

  // One result beat on the output channel
  typedef struct packed {
    logic       read_valid;
    logic [7:0] read_byte;
    logic       send_accepted;
    logic       kbd_tx_valid;
    logic [7:0] kbd_tx_byte;
    logic       mouse_tx_valid;
    logic [7:0] mouse_tx_byte;
    logic [3:0] kbd_rx_count;
    logic [3:0] mouse_rx_count;
    logic [1:0] rx_dropped;
  } ps2_res_t;

  typedef struct {
    int       reps;
    ps2_op_t  beat;
    bit       fixed;
    ps2_res_t want;
  } dir_row_t;

  typedef enum int {KBD_RX, KBD_TX, MS_RX, MS_TX} ring_e;

  localparam ps2_res_t NIL = '0;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] op_i = OP_POLL;
  logic       channel_i = CH_KBD;
  logic [7:0] send_byte_i = '0;
  logic       kbd_received_i = 1'b0;
  logic       kbd_clear_to_send_i = 1'b0;
  logic [7:0] kbd_rx_byte_i = '0;
  logic       mouse_received_i = 1'b0;
  logic       mouse_clear_to_send_i = 1'b0;
  logic [7:0] mouse_rx_byte_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       read_valid_o;
  logic [7:0] read_byte_o;
  logic       send_accepted_o;
  logic       kbd_tx_valid_o;
  logic [7:0] kbd_tx_byte_o;
  logic       mouse_tx_valid_o;
  logic [7:0] mouse_tx_byte_o;
  logic [3:0] kbd_rx_count_o;
  logic [3:0] mouse_rx_count_o;
  logic [1:0] rx_dropped_o;

  ps2_dual_port_ring_buffers dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .op_i                  (op_i),
    .channel_i             (channel_i),
    .send_byte_i           (send_byte_i),
    .kbd_received_i        (kbd_received_i),
    .kbd_clear_to_send_i   (kbd_clear_to_send_i),
    .kbd_rx_byte_i         (kbd_rx_byte_i),
    .mouse_received_i      (mouse_received_i),
    .mouse_clear_to_send_i (mouse_clear_to_send_i),
    .mouse_rx_byte_i       (mouse_rx_byte_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .read_valid_o          (read_valid_o),
    .read_byte_o           (read_byte_o),
    .send_accepted_o       (send_accepted_o),
    .kbd_tx_valid_o        (kbd_tx_valid_o),
    .kbd_tx_byte_o         (kbd_tx_byte_o),
    .mouse_tx_valid_o      (mouse_tx_valid_o),
    .mouse_tx_byte_o       (mouse_tx_byte_o),
    .kbd_rx_count_o        (kbd_rx_count_o),
    .mouse_rx_count_o      (mouse_rx_count_o),
    .rx_dropped_o          (rx_dropped_o)
  );

  always #5 clk_i = ~clk_i;

  // Ring shadow state, empty after reset
  logic [7:0]       ring_mem [4][DEPTH];
  logic [PTR_W-1:0] ring_hd [4] = '{default: '0};
  logic [PTR_W-1:0] ring_tl [4] = '{default: '0};

  ps2_res_t  pending_res_q [$];
  int        mismatch_cnt = 0;
  bit        idle_on = 1'b1;
  bit        stall_on = 1'b1;
  int        ready_hold = 0;
  dir_row_t  dir_tab [N_DIR];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic bit ring_put(input ring_e r, input logic [7:0] v);
    logic [PTR_W-1:0] nt;
    nt = ptr_inc(ring_tl[r]);
    if (nt == ring_hd[r]) return 1'b0;
    ring_mem[r][ring_tl[r]] = v;
    ring_tl[r] = nt;
    return 1'b1;
  endfunction

  function automatic bit ring_take(input ring_e r, output logic [7:0] v);
    v = '0;
    if (ring_hd[r] == ring_tl[r]) return 1'b0;
    v = ring_mem[r][ring_hd[r]];
    ring_hd[r] = ptr_inc(ring_hd[r]);
    return 1'b1;
  endfunction

  // Bytes waiting, saturated to the 4-bit count field
  function automatic logic [3:0] ring_fill(input ring_e r);
    int n;
    n = int'(ring_tl[r]) - int'(ring_hd[r]);
    if (n < 0) n += DEPTH;
    return (n > 15) ? 4'd15 : 4'(n);
  endfunction

  // Store a flagged rx byte first, then hand the oldest tx byte to the port
  function automatic void port_service(input ring_e rx, input ring_e tx, input logic rcv,
                                       input logic cts, input logic [7:0] rb,
                                       output logic drop, output logic tv,
                                       output logic [7:0] tb);
    drop = 1'b0;
    tv   = 1'b0;
    tb   = '0;
    if (rcv) drop = !ring_put(rx, rb);
    if (cts) tv = ring_take(tx, tb);
  endfunction

  function automatic ps2_res_t ring_model_step(input ps2_op_t b);
    ps2_res_t   r;
    logic [7:0] v, ktb, mtb;
    logic       kd, md, ktv, mtv;
    r = '0;
    v = '0;
    case (b.op)
      OP_SEND: r.send_accepted = ring_put((b.ch == CH_KBD) ? KBD_TX : MS_TX, b.send_byte);
      OP_READ: begin
        r.read_valid = ring_take((b.ch == CH_KBD) ? KBD_RX : MS_RX, v);
        r.read_byte  = v;
      end
      default: ;
    endcase
    // Send and poll both service the ports, keyboard first
    if (b.op == OP_SEND || b.op == OP_POLL) begin
      port_service(KBD_RX, KBD_TX, b.kbd_rcv, b.kbd_cts, b.kbd_byte, kd, ktv, ktb);
      port_service(MS_RX, MS_TX, b.ms_rcv, b.ms_cts, b.ms_byte, md, mtv, mtb);
      r.kbd_tx_valid   = ktv;
      r.kbd_tx_byte    = ktb;
      r.mouse_tx_valid = mtv;
      r.mouse_tx_byte  = mtb;
      r.rx_dropped     = {md, kd};
    end
    r.kbd_rx_count   = ring_fill(KBD_RX);
    r.mouse_rx_count = ring_fill(MS_RX);
    return r;
  endfunction

  function automatic bit field_diff(input string name, input int want, input int got);
    if (want == got) return 1'b0;
    if (mismatch_cnt < 10)
      $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, name, want, got);
    return 1'b1;
  endfunction

  task automatic check_res(input ps2_res_t got);
    ps2_res_t want;
    bit       bad;
    if (pending_res_q.size() == 0) begin
      if (mismatch_cnt < 10) $display("%0t: result beat with none pending: %p", $realtime, got);
      mismatch_cnt++;
      return;
    end
    want = pending_res_q.pop_front();
    bad = 1'b0;
    bad |= field_diff("read_valid", want.read_valid, got.read_valid);
    bad |= field_diff("read_byte", want.read_byte, got.read_byte);
    bad |= field_diff("send_accepted", want.send_accepted, got.send_accepted);
    bad |= field_diff("kbd_tx_valid", want.kbd_tx_valid, got.kbd_tx_valid);
    bad |= field_diff("kbd_tx_byte", want.kbd_tx_byte, got.kbd_tx_byte);
    bad |= field_diff("mouse_tx_valid", want.mouse_tx_valid, got.mouse_tx_valid);
    bad |= field_diff("mouse_tx_byte", want.mouse_tx_byte, got.mouse_tx_byte);
    bad |= field_diff("kbd_rx_count", want.kbd_rx_count, got.kbd_rx_count);
    bad |= field_diff("mouse_rx_count", want.mouse_rx_count, got.mouse_rx_count);
    bad |= field_diff("rx_dropped", want.rx_dropped, got.rx_dropped);
    if (bad) mismatch_cnt++;
  endtask

  // Result side: take beats, stall ready at random between them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        check_res('{read_valid_o, read_byte_o, send_accepted_o, kbd_tx_valid_o,
                    kbd_tx_byte_o, mouse_tx_valid_o, mouse_tx_byte_o,
                    kbd_rx_count_o, mouse_rx_count_o, rx_dropped_o});
        if ($urandom_range(0, 39) == 0) stall_on = !stall_on;
        ready_hold = stall_on ? $urandom_range(0, 10) : 0;
      end
      if (ready_hold != 0) begin
        out_ready_i <= 1'b0;
        ready_hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Drive one op beat, hold it until taken, then log what it should produce
  task automatic push_op(input ps2_op_t b, input bit fixed, input ps2_res_t want);
    int       gap;
    ps2_res_t exp_res;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    op_i                  <= b.op;
    channel_i             <= b.ch;
    send_byte_i           <= b.send_byte;
    kbd_received_i        <= b.kbd_rcv;
    kbd_clear_to_send_i   <= b.kbd_cts;
    kbd_rx_byte_i         <= b.kbd_byte;
    mouse_received_i      <= b.ms_rcv;
    mouse_clear_to_send_i <= b.ms_cts;
    mouse_rx_byte_i       <= b.ms_byte;
    do @(posedge clk_i); while (!in_ready_o);
    exp_res = ring_model_step(b);
    pending_res_q.push_back(fixed ? want : exp_res);
  endtask

  function automatic bit pct(input int p);
    return $urandom_range(0, 99) < p;
  endfunction

  // Random op, biased by traffic mode: 0 mixed, 1 fill rings, 2 drain rings
  function automatic ps2_op_t rand_op(input int mode);
    ps2_op_t b;
    int      roll, p_send, p_read, p_rcv, p_cts;
    case (mode)
      1:       begin p_send = 40; p_read = 10; p_rcv = 80; p_cts = 20; end
      2:       begin p_send = 15; p_read = 50; p_rcv = 20; p_cts = 80; end
      default: begin p_send = 33; p_read = 33; p_rcv = 50; p_cts = 50; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 3)                        b.op = OP_NONE;
    else if (roll < 3 + p_send)          b.op = OP_SEND;
    else if (roll < 3 + p_send + p_read) b.op = OP_READ;
    else                                 b.op = OP_POLL;
    b.ch        = 1'($urandom_range(0, 1));
    b.send_byte = 8'($urandom_range(0, 255));
    b.kbd_rcv   = pct(p_rcv);
    b.kbd_cts   = pct(p_cts);
    b.kbd_byte  = 8'($urandom_range(0, 255));
    b.ms_rcv    = pct(p_rcv);
    b.ms_cts    = pct(p_cts);
    b.ms_byte   = 8'($urandom_range(0, 255));
    return b;
  endfunction

  initial begin
    int mode;
    dir_tab = '{
      // empty reads; a read must not poll even with status raised
      '{1, '{OP_READ, CH_KBD, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00}, 1'b1, NIL},
      '{1, '{OP_READ, CH_MOUSE, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 8'hFF}, 1'b1, NIL},
      // undefined op does nothing
      '{1, '{OP_NONE, CH_MOUSE, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 8'hFF}, 1'b1, NIL},
      // queue one byte per port, then emit both
      '{1, '{OP_SEND, CH_KBD, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
       1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00, 4'd0, 4'd0, 2'd0}},
      '{1, '{OP_SEND, CH_MOUSE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
       1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00, 4'd0, 4'd0, 2'd0}},
      '{1, '{OP_POLL, CH_KBD, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 8'h00},
       1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b1, 8'h00, 4'd0, 4'd0, 2'd0}},
      // receive one byte per port, tx rings empty
      '{1, '{OP_POLL, CH_KBD, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 8'h00},
       1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 4'd1, 4'd1, 2'd0}},
      '{1, '{OP_READ, CH_KBD, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
       1'b1, '{1'b1, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 4'd0, 4'd1, 2'd0}},
      '{1, '{OP_READ, CH_MOUSE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
       1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 4'd0, 4'd0, 2'd0}},
      // fill both rx rings, then overflow both
      '{15, '{OP_POLL, CH_KBD, 8'h00, 1'b1, 1'b0, 8'hA5, 1'b1, 1'b0, 8'h5A}, 1'b0, NIL},
      '{1, '{OP_POLL, CH_KBD, 8'h00, 1'b1, 1'b0, 8'h3C, 1'b1, 1'b0, 8'hC3},
       1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 4'd15, 4'd15, 2'd3}},
      '{1, '{OP_READ, CH_KBD, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
       1'b1, '{1'b1, 8'hA5, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 4'd14, 4'd15, 2'd0}},
      // keyboard has room again, mouse still full
      '{1, '{OP_POLL, CH_KBD, 8'h00, 1'b1, 1'b0, 8'h11, 1'b1, 1'b0, 8'h22},
       1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 4'd15, 4'd15, 2'd2}},
      // fill mouse tx, then a refused send
      '{15, '{OP_SEND, CH_MOUSE, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00}, 1'b0, NIL},
      '{1, '{OP_SEND, CH_MOUSE, 8'h7F, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
       1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 4'd15, 4'd15, 2'd0}},
      // send passes straight through to the port in the same beat
      '{1, '{OP_SEND, CH_KBD, 8'h01, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 8'h00},
       1'b1, '{1'b0, 8'h00, 1'b1, 1'b1, 8'h01, 1'b1, 8'h80, 4'd15, 4'd15, 2'd0}},
      // drain everything, past empty
      '{16, '{OP_READ, CH_KBD, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00}, 1'b0, NIL},
      '{16, '{OP_READ, CH_MOUSE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00}, 1'b0, NIL},
      '{15, '{OP_POLL, CH_KBD, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 8'h00}, 1'b0, NIL},
      // fill keyboard tx, then a refused send
      '{15, '{OP_SEND, CH_KBD, 8'hFE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00}, 1'b0, NIL},
      '{1, '{OP_SEND, CH_KBD, 8'h02, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
       1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 4'd0, 4'd0, 2'd0}},
      // receive and transmit together on the keyboard
      '{16, '{OP_POLL, CH_KBD, 8'h00, 1'b1, 1'b1, 8'h5C, 1'b0, 1'b0, 8'h00}, 1'b0, NIL},
      '{2, '{OP_NONE, CH_KBD, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 8'hFF}, 1'b0, NIL}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    for (int i = 0; i < N_DIR; i++)
      repeat (dir_tab[i].reps) push_op(dir_tab[i].beat, dir_tab[i].fixed, dir_tab[i].want);

    // Random traffic in chunks of one mode each
    mode = 0;
    for (int i = 0; i < N_RAND; i++) begin
      if (i % CHUNK == 0) begin
        mode    = $urandom_range(0, 2);
        idle_on = $urandom_range(0, 3) != 0;
      end
      push_op(rand_op(mode), 1'b0, NIL);
    end
    in_valid_i <= 1'b0;

    // Drain the pending results, then report the verdict
    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_res_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
